// ----- hw/rtl/sem_pkg.sv -----
package sem_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [11:0] WIDTH_RESET = 12'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [11:0] WIDTH_MIN = 12'd2;
    localparam logic [11:0] WIDTH_MAX = 12'(MAX_WIDTH);
    localparam logic [15:0] HEIGHT_MIN = 16'd2;

    // write side of both line stores, one entry each
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        upper;
        logic [7:0]        lower;
    } ls_wr_t;

endpackage

// ----- hw/rtl/sem_line_store.sv -----
module sem_line_store (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [sem_pkg::ADDR_W-1:0] rd_addr,
    input  sem_pkg::ls_wr_t            wr,
    output logic [7:0]                 upper_q,
    output logic [7:0]                 lower_q
);

    logic [7:0] upper_mem [sem_pkg::MAX_WIDTH];
    logic [7:0] lower_mem [sem_pkg::MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            upper_mem[wr.addr] <= wr.upper;
            lower_mem[wr.addr] <= wr.lower;
        end
        if (rd_en)
        begin
            upper_q <= upper_mem[rd_addr];
            lower_q <= lower_mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/sem_magnitude.sv -----
module sem_magnitude (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [10:0] gx,
    input  logic signed [10:0] gy,
    output logic               done,
    output logic [7:0]         mag
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_SQ   = 5'b00010,
        M_SUM  = 5'b00100,
        M_ROOT = 5'b01000,
        M_FIN  = 5'b10000
    } mstate_t;

    mstate_t            state_reg, state_next;
    logic signed [10:0] gx_reg, gy_reg;
    logic [19:0]        px_reg, py_reg;
    logic [20:0]        s_reg;
    logic [7:0]         q_reg, bit_reg;
    logic [7:0]         mag_reg;
    logic               done_reg;

    logic signed [21:0] gx_sq, gy_sq;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;
    logic [16:0]        q_sq_q;

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;
    assign trial = q_reg | bit_reg;
    assign trial_sq = trial * trial;
    assign q_sq_q = 17'(q_reg * q_reg) + 17'(q_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: if (start) state_next = M_SQ;
            M_SQ:   state_next = M_SUM;
            M_SUM:  state_next = M_ROOT;
            M_ROOT: if (bit_reg == 8'd1) state_next = M_FIN;
            M_FIN:  state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == M_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                gx_reg <= gx;
                gy_reg <= gy;
            end
            M_SQ:
            begin
                px_reg <= gx_sq[19:0];
                py_reg <= gy_sq[19:0];
            end
            M_SUM:
            begin
                s_reg <= {1'b0, px_reg} + {1'b0, py_reg};
                q_reg <= 8'd0;
                bit_reg <= 8'h80;
            end
            M_ROOT:
            begin
                if ({5'd0, trial_sq} <= s_reg)
                    q_reg <= trial;
                bit_reg <= bit_reg >> 1;
            end
            M_FIN:
            begin
                // anything above 255*256 rounds to 256 or more
                if (s_reg > 21'd65280)
                    mag_reg <= 8'd255;
                else if (s_reg > {4'd0, q_sq_q} && q_reg != 8'd255)
                    mag_reg <= q_reg + 8'd1;
                else
                    mag_reg <= q_reg;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign mag = mag_reg;

endmodule

// ----- hw/rtl/sobel_edge_magnitude_top.sv -----
// channel   | valid        | stall        | payload
// pixel in  | pixel_valid  | pixel_stall  | pixel_value
// result    | result_valid | result_stall | edge_magnitude, grad_x, grad_y,
//           |              |              | last_of_run, end_of_frame
// config    | cfg_write_en | -            | cfg_index, cfg_data
// an item is accepted, read from the line stores and shifted into the window;
// each result it causes then passes through the 8-step square root unit
// reset clears counters, window and control; line stores are not cleared
// a finished result waits in the output register, the next one is computed
// meanwhile; a new pixel is taken while the last result still waits
module sobel_edge_magnitude_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic [7:0]                     pixel_value,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [7:0]                     edge_magnitude,
    output logic signed [10:0]             grad_x,
    output logic signed [10:0]             grad_y,
    output logic                           last_of_run,
    output logic                           end_of_frame
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_UPD  = 6'b000100,
        S_GRAD = 6'b001000,
        S_MAG  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [11:0]                width_reg;
    logic [15:0]                height_reg;
    logic [sem_pkg::ADDR_W-1:0] col_reg;
    logic [15:0]                row_reg;
    logic [7:0]                 pix_reg;
    logic [2:0][2:0][7:0]       win_reg;
    logic [3:0]                 emit_reg;
    logic                       row1_reg, col1_reg, cur_eof_reg;
    logic                       out_valid_reg, out_last_reg, out_eof_reg;
    logic [7:0]                 out_mag_reg;
    logic signed [10:0]         out_gx_reg, out_gy_reg, gx_reg, gy_reg;

    logic [11:0]                w_eff, w_m1;
    logic [15:0]                h_eff, h_m1;
    logic                       at_last_col, at_last_row, col_nz, row_nz;
    logic [7:0]                 top_q, mid_q;
    sem_pkg::ls_wr_t            ls_wr;
    logic                       mag_done;
    logic [7:0]                 mag_val;
    logic                       out_free;

    logic [1:0]                 rsel [3];
    logic [1:0]                 csel [3];
    logic [7:0]                 a [3][3];
    logic [9:0]                 sum_r, sum_l, sum_b, sum_t;
    logic signed [10:0]         gx_c, gy_c;
    logic                       use_last_rows, use_edge_cols;
    logic [1:0]                 pick;
    logic [3:0]                 emit_left;

    assign w_eff = (width_reg < sem_pkg::WIDTH_MIN) ? sem_pkg::WIDTH_MIN :
                   (width_reg > sem_pkg::WIDTH_MAX) ? sem_pkg::WIDTH_MAX : width_reg;
    assign h_eff = (height_reg < sem_pkg::HEIGHT_MIN) ? sem_pkg::HEIGHT_MIN : height_reg;
    assign w_m1 = w_eff - 12'd1;
    assign h_m1 = h_eff - 16'd1;
    assign at_last_col = ({1'b0, col_reg} == w_m1);
    assign at_last_row = (row_reg == h_m1);
    assign col_nz = (col_reg != '0);
    assign row_nz = (row_reg != '0);

    assign ls_wr.en = (state_reg == S_UPD);
    assign ls_wr.addr = col_reg;
    assign ls_wr.upper = mid_q;
    assign ls_wr.lower = pix_reg;

    sem_line_store u_line_store (
        .clk     (clk),
        .rd_en   (state_reg == S_READ),
        .rd_addr (col_reg),
        .wr      (ls_wr),
        .upper_q (top_q),
        .lower_q (mid_q)
    );

    sem_magnitude u_magnitude (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_GRAD),
        .gx    (gx_c),
        .gy    (gy_c),
        .done  (mag_done),
        .mag   (mag_val)
    );

    // pending results go out in order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
    always_comb
    begin
        pick = 2'd3;
        if (emit_reg[0])
            pick = 2'd0;
        else if (emit_reg[1])
            pick = 2'd1;
        else if (emit_reg[2])
            pick = 2'd2;
        emit_left = emit_reg & ~(4'd1 << pick);
        use_last_rows = pick[1];
        use_edge_cols = pick[0];
    end

    // border replication by choosing window rows and columns
    always_comb
    begin
        rsel[0] = use_last_rows ? 2'd1 : (row1_reg ? 2'd1 : 2'd0);
        rsel[1] = use_last_rows ? 2'd2 : 2'd1;
        rsel[2] = 2'd2;
        csel[0] = use_edge_cols ? 2'd1 : (col1_reg ? 2'd1 : 2'd0);
        csel[1] = use_edge_cols ? 2'd2 : 2'd1;
        csel[2] = 2'd2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = win_reg[rsel[i]][csel[j]];
        sum_r = 10'(a[0][2]) + {1'b0, a[1][2], 1'b0} + 10'(a[2][2]);
        sum_l = 10'(a[0][0]) + {1'b0, a[1][0], 1'b0} + 10'(a[2][0]);
        sum_b = 10'(a[2][0]) + {1'b0, a[2][1], 1'b0} + 10'(a[2][2]);
        sum_t = 10'(a[0][0]) + {1'b0, a[0][1], 1'b0} + 10'(a[0][2]);
        gx_c = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        gy_c = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (pixel_valid) state_next = S_READ;
            S_READ: state_next = S_UPD;
            S_UPD:
            begin
                if ((row_nz && col_nz) || (row_nz && at_last_col) ||
                    (at_last_row && col_nz) || (at_last_row && at_last_col))
                    state_next = S_GRAD;
                else
                    state_next = S_IDLE;
            end
            S_GRAD: state_next = S_MAG;
            S_MAG:  if (mag_done) state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = (emit_reg != '0) ? S_GRAD : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= sem_pkg::WIDTH_RESET;
            height_reg <= sem_pkg::HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
            emit_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                if (cfg_index == sem_pkg::REG_FRAME_WIDTH)
                begin
                    width_reg <= cfg_data[11:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (cfg_index == sem_pkg::REG_FRAME_HEIGHT)
                begin
                    height_reg <= cfg_data[15:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
            if (state_reg == S_UPD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top_q;
                win_reg[1][2] <= mid_q;
                win_reg[2][2] <= pix_reg;
                emit_reg <= {at_last_row && at_last_col, at_last_row && col_nz,
                             row_nz && at_last_col, row_nz && col_nz};
                if (at_last_col)
                begin
                    col_reg <= '0;
                    row_reg <= at_last_row ? 16'd0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (state_reg == S_GRAD)
                emit_reg <= emit_left;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pixel_valid)
            pix_reg <= pixel_value;
        if (state_reg == S_UPD)
        begin
            row1_reg <= (row_reg == 16'd1);
            col1_reg <= (col_reg == 1);
        end
        if (state_reg == S_GRAD)
        begin
            gx_reg <= gx_c;
            gy_reg <= gy_c;
            cur_eof_reg <= (pick == 2'd3);
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_mag_reg <= mag_val;
            out_gx_reg <= gx_reg;
            out_gy_reg <= gy_reg;
            out_last_reg <= (emit_reg == '0);
            out_eof_reg <= cur_eof_reg;
        end
    end

    assign pixel_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign edge_magnitude = out_mag_reg;
    assign grad_x = out_gx_reg;
    assign grad_y = out_gy_reg;
    assign last_of_run = out_last_reg;
    assign end_of_frame = out_eof_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS = 330;

    typedef struct {
        logic [7:0]         mag;
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic               last;
        logic               eof;
    } grad_t;

    typedef struct {
        logic [7:0] pix;
        bit         typed;
        logic [7:0] mag;
        int         gx;
        int         gy;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write_en;
    logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            pixel_valid;
    logic                            pixel_stall;
    logic [7:0]                      pixel_value;
    logic                            result_valid;
    logic                            result_stall;
    logic [7:0]                      edge_magnitude;
    logic signed [10:0]              grad_x;
    logic signed [10:0]              grad_y;
    logic                            last_of_run;
    logic                            end_of_frame;

    sobel_edge_magnitude_top dut (.*);

    // predictor state
    logic [7:0]  up_line [0:sem_pkg::MAX_WIDTH-1];
    logic [7:0]  lo_line [0:sem_pkg::MAX_WIDTH-1];
    logic [7:0]  win [0:2][0:2];
    int unsigned col_pos, row_pos, fw_reg, fh_reg;

    grad_t want_q[$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    frames_seen = 0;
    int    pixels_sent = 0;
    int    cycles = 0;
    int    burst_left = 0;
    bit    held_off = 0;

    // 2x2 frames: vertical step, reversed, horizontal step, reversed, flat
    dir_row_t dir_tab [0:19] = '{
        '{8'd0,   1, 8'd255, 1020, 0}, '{8'd255, 1, 8'd255, 1020, 0},
        '{8'd0,   1, 8'd255, 1020, 0}, '{8'd255, 1, 8'd255, 1020, 0},
        '{8'd255, 1, 8'd255, -1020, 0}, '{8'd0,  1, 8'd255, -1020, 0},
        '{8'd255, 1, 8'd255, -1020, 0}, '{8'd0,  1, 8'd255, -1020, 0},
        '{8'd0,   1, 8'd255, 0, 1020}, '{8'd0,   1, 8'd255, 0, 1020},
        '{8'd255, 1, 8'd255, 0, 1020}, '{8'd255, 1, 8'd255, 0, 1020},
        '{8'd255, 1, 8'd255, 0, -1020}, '{8'd255, 1, 8'd255, 0, -1020},
        '{8'd0,   1, 8'd255, 0, -1020}, '{8'd0,   1, 8'd255, 0, -1020},
        '{8'd128, 1, 8'd0, 0, 0}, '{8'd128, 1, 8'd0, 0, 0},
        '{8'd128, 1, 8'd0, 0, 0}, '{8'd128, 1, 8'd0, 0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("sobel_edge_magnitude_top regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] rounded_root(int unsigned s);
        int unsigned q;
        int unsigned t;
        q = 0;
        if (s > 65280) return 8'd255;
        for (int b = 128; b != 0; b = b >> 1)
        begin
            t = q | b;
            if (t * t <= s) q = t;
        end
        if (s > q * q + q) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic grad_t grad_at(int r0, int r1, int r2, int c0, int c1, int c2);
        int    rs[3];
        int    cs[3];
        int    a[3][3];
        int    gx, gy;
        grad_t g;
        rs = '{r0, r1, r2};
        cs = '{c0, c1, c2};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = win[rs[i]][cs[j]];
        gx = (a[0][2] + 2 * a[1][2] + a[2][2]) - (a[0][0] + 2 * a[1][0] + a[2][0]);
        gy = (a[2][0] + 2 * a[2][1] + a[2][2]) - (a[0][0] + 2 * a[0][1] + a[0][2]);
        g.mag = rounded_root(gx * gx + gy * gy);
        g.gx = gx[10:0];
        g.gy = gy[10:0];
        g.last = 1'b0;
        g.eof = 1'b0;
        return g;
    endfunction

    // advance the window for one pixel and queue the gradients it releases
    function automatic void predict_pixel(logic [7:0] p, dir_row_t row);
        int unsigned w, h, c, r;
        int    n;
        int    rm0, cm0;
        grad_t res[4];
        w = (fw_reg < 2) ? 2 : ((fw_reg > sem_pkg::MAX_WIDTH) ? sem_pkg::MAX_WIDTH : fw_reg);
        h = (fh_reg < 2) ? 2 : fh_reg;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up_line[c];
        win[1][2] = lo_line[c];
        win[2][2] = p;
        up_line[c] = lo_line[c];
        lo_line[c] = p;
        rm0 = (r == 1) ? 1 : 0;
        cm0 = (c == 1) ? 1 : 0;
        if (r >= 1 && c >= 1)
        begin
            res[n] = grad_at(rm0, 1, 2, cm0, 1, 2);
            n++;
        end
        if (r >= 1 && c == w - 1)
        begin
            res[n] = grad_at(rm0, 1, 2, 1, 2, 2);
            n++;
        end
        if (r == h - 1 && c >= 1)
        begin
            res[n] = grad_at(1, 2, 2, cm0, 1, 2);
            n++;
        end
        if (r == h - 1 && c == w - 1)
        begin
            res[n] = grad_at(1, 2, 2, 1, 2, 2);
            res[n].eof = 1'b1;
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (row.typed)
            begin
                res[i].mag = row.mag;
                res[i].gx = row.gx[10:0];
                res[i].gy = row.gy[10:0];
            end
            want_q.push_back(res[i]);
        end
        if (c == w - 1)
        begin
            c = 0;
            r = (r == h - 1) ? 0 : r + 1;
        end
        else
        begin
            c++;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        grad_t g;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (end_of_frame) frames_seen++;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: mag %0d gx %0d gy %0d", edge_magnitude,
                             grad_x, grad_y);
            end
            else
            begin
                g = want_q.pop_front();
                if (edge_magnitude !== g.mag || grad_x !== g.gx || grad_y !== g.gy ||
                    last_of_run !== g.last || end_of_frame !== g.eof)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0d: want mag %0d gx %0d gy %0d last %b ",
                                  "eof %b, got mag %0d gx %0d gy %0d last %b eof %b"},
                                 results_seen, g.mag, g.gx, g.gy, g.last, g.eof,
                                 edge_magnitude, grad_x, grad_y, last_of_run, end_of_frame);
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off to fill the pipe
    initial
    begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= 120)
            begin
                held_off = 1;
                result_stall = 1'b1;
                repeat (400) @(negedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(5, 60);
            end
            span--;
            case (mode)
                0: result_stall = 1'b0;
                1: result_stall = ($urandom_range(0, 3) == 0);
                2: result_stall = $urandom_range(0, 1);
                default: result_stall = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(logic [7:0] p, dir_row_t row);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                pixel_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        burst_left--;
        pixel_valid = 1'b1;
        pixel_value = p;
        do @(posedge clk); while (pixel_stall);
        predict_pixel(p, row);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(logic [7:0] p);
        dir_row_t none;
        none = '{8'd0, 1'b0, 8'd0, 0, 0};
        send_pixel(p, none);
    endtask

    task automatic drain_idle();
        pixel_valid = 1'b0;
        while (want_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [sem_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == sem_pkg::REG_FRAME_WIDTH) fw_reg = val[11:0];
        else fh_reg = val;
        col_pos = 0;
        row_pos = 0;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic set_frame(logic [15:0] w, logic [15:0] h);
        if ($urandom_range(0, 1))
        begin
            write_reg(sem_pkg::REG_FRAME_WIDTH, w);
            write_reg(sem_pkg::REG_FRAME_HEIGHT, h);
        end
        else
        begin
            write_reg(sem_pkg::REG_FRAME_HEIGHT, h);
            write_reg(sem_pkg::REG_FRAME_WIDTH, w);
        end
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int w, h, npix, rand_sent;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_valid = 1'b0;
        pixel_value = '0;
        for (int i = 0; i < sem_pkg::MAX_WIDTH; i++)
        begin
            up_line[i] = '0;
            lo_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        col_pos = 0;
        row_pos = 0;
        fw_reg = sem_pkg::WIDTH_RESET;
        fh_reg = sem_pkg::HEIGHT_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset size: part of the first row, nothing is released yet
        for (int i = 0; i < 24; i++) send_plain(rand_pixel());
        drain_idle();

        set_frame(16'd2, 16'd2);
        for (int i = 0; i < 20; i++) send_pixel(dir_tab[i].pix, dir_tab[i]);
        drain_idle();

        // sizes below the minimum act as 2x2
        set_frame(16'd0, 16'd1);
        for (int i = 0; i < 8; i++) send_plain(rand_pixel());
        drain_idle();
        set_frame(16'd1, 16'd0);
        for (int i = 0; i < 4; i++) send_plain(rand_pixel());
        drain_idle();

        // widest frame, abandoned within the first row
        set_frame(16'hFFFF, 16'd2);
        for (int i = 0; i < 24; i++) send_plain(rand_pixel());
        drain_idle();

        // tallest frame, abandoned part way by the next write
        set_frame(16'd3, 16'hFFFF);
        for (int i = 0; i < 40; i++) send_plain(rand_pixel());
        drain_idle();

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 6);
            set_frame(w, h);
            npix = w * h;
            if ($urandom_range(0, 5) == 0) npix = $urandom_range(1, w * h - 1);
            else if ($urandom_range(0, 4) == 0) npix = w * h * 2;
            for (int i = 0; i < npix; i++) send_plain(rand_pixel());
            rand_sent += npix;
            drain_idle();
        end

        drain_idle();
        $display("sent %0d pixels, checked %0d gradients over %0d finished frames",
                 pixels_sent, results_seen, frames_seen);
        $display("small and random frame sizes, clamped and abandoned frames, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && want_q.size() == 0)
            $display("sobel_edge_magnitude_top regression: pass");
        else
            $display("sobel_edge_magnitude_top regression: fail");
        $finish;
    end

endmodule
